@@ rtl/cosf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Circular orbit steering force: shared package
// Word widths, register map codes, saturation limits and a magnitude helper
// used by the pipeline modules.
// ----------------------------------------------------------------------------
package cosf_pkg;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;

	localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		REG_ENABLE,
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_CENTER_Z,
		REG_INNER_RADIUS,
		REG_OUTER_RADIUS,
		REG_RADIAL_GAIN,
		REG_TANGENT_GAIN
	} cosf_reg_t;

	// Magnitude of a signed word; the most negative value maps to 2^31.
	function automatic logic [DATA_W-1:0] mag_of(input logic signed [DATA_W-1:0] v);
		logic [DATA_W-1:0] m;
		m = v[DATA_W-1] ? DATA_W'(-v) : v;
		return m;
	endfunction

endpackage
`default_nettype wire

@@ rtl/cosf_norm3.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined 3D vector normalizer
// Squares the component magnitudes, takes the floor square root one result
// bit per stage, then divides each scaled magnitude by the length one
// quotient bit per stage. A zero length gives a zero unit vector.
// ----------------------------------------------------------------------------
module cosf_norm3 import cosf_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int PW        = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic [2:0][DATA_W-1:0]        vec_in,
	input  logic [PW-1:0]                 pay_in,
	output logic                          out_valid,
	output logic [2:0][FRAC_BITS+1:0]     unit_out,
	output logic [DATA_W-1:0]             len_out,
	output logic [PW-1:0]                 pay_out
);

	localparam int SQ_W     = 2 * DATA_W;
	localparam int REM_W    = DATA_W + 3;
	localparam int RT_STEPS = DATA_W;
	localparam int Q_W      = FRAC_BITS + 1;
	localparam int DV_STEPS = Q_W;
	localparam int U_W      = FRAC_BITS + 2;

	logic                   vld_s1, vld_s2, vld_s3;
	logic [2:0][DATA_W-1:0] mag_s1, mag_s2, mag_s3;
	logic [2:0]             neg_s1, neg_s2, neg_s3;
	logic [PW-1:0]          pay_s1, pay_s2, pay_s3;
	logic [2:0][SQ_W-1:0]   sq_s2;
	logic [SQ_W-1:0]        sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				mag_s1[j] <= mag_of(vec_in[j]);
				neg_s1[j] <= vec_in[j][DATA_W-1];
				sq_s2[j]  <= SQ_W'(mag_s1[j] * mag_s1[j]);
			end
			pay_s1 <= pay_in;
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			pay_s2 <= pay_s1;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			pay_s3 <= pay_s2;
		end
	end

	// Square root stages.
	logic                   vld_rt_s  [0:RT_STEPS];
	logic [SQ_W-1:0]        rad_rt_s  [0:RT_STEPS];
	logic [REM_W-1:0]       rem_rt_s  [0:RT_STEPS];
	logic [DATA_W-1:0]      root_rt_s [0:RT_STEPS];
	logic [2:0][DATA_W-1:0] mag_rt_s  [0:RT_STEPS];
	logic [2:0]             neg_rt_s  [0:RT_STEPS];
	logic [PW-1:0]          pay_rt_s  [0:RT_STEPS];

	assign vld_rt_s[0]  = vld_s3;
	assign rad_rt_s[0]  = sum_s3;
	assign rem_rt_s[0]  = '0;
	assign root_rt_s[0] = '0;
	assign mag_rt_s[0]  = mag_s3;
	assign neg_rt_s[0]  = neg_s3;
	assign pay_rt_s[0]  = pay_s3;

	for (genvar k = 0; k < RT_STEPS; k++) begin : g_rt
		logic [REM_W-1:0] raw;
		logic [REM_W-1:0] trial;
		logic             take;

		always_comb begin
			raw   = {rem_rt_s[k][REM_W-3:0], rad_rt_s[k][SQ_W-1 -: 2]};
			trial = {1'b0, root_rt_s[k], 2'b01};
			take  = (raw >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_rt_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_rt_s[k+1] <= vld_rt_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rad_rt_s[k+1]  <= {rad_rt_s[k][SQ_W-3:0], 2'b00};
				rem_rt_s[k+1]  <= take ? raw - trial : raw;
				root_rt_s[k+1] <= {root_rt_s[k][DATA_W-2:0], take};
				mag_rt_s[k+1]  <= mag_rt_s[k];
				neg_rt_s[k+1]  <= neg_rt_s[k];
				pay_rt_s[k+1]  <= pay_rt_s[k];
			end
		end
	end

	// Division stages, one quotient bit per stage for all three lanes.
	logic                   vld_dv_s [0:DV_STEPS];
	logic [DATA_W-1:0]      len_dv_s [0:DV_STEPS];
	logic [2:0][DATA_W-1:0] rem_dv_s [0:DV_STEPS];
	logic [2:0]             nb_dv_s  [0:DV_STEPS];
	logic [2:0][Q_W-1:0]    q_dv_s   [0:DV_STEPS];
	logic [2:0]             neg_dv_s [0:DV_STEPS];
	logic [PW-1:0]          pay_dv_s [0:DV_STEPS];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			rem_dv_s[0][j] = {1'b0, mag_rt_s[RT_STEPS][j][DATA_W-1:1]};
			nb_dv_s[0][j]  = mag_rt_s[RT_STEPS][j][0];
		end
	end

	assign vld_dv_s[0] = vld_rt_s[RT_STEPS];
	assign len_dv_s[0] = root_rt_s[RT_STEPS];
	assign q_dv_s[0]   = '0;
	assign neg_dv_s[0] = neg_rt_s[RT_STEPS];
	assign pay_dv_s[0] = pay_rt_s[RT_STEPS];

	for (genvar k = 0; k < DV_STEPS; k++) begin : g_dv
		logic [2:0][DATA_W:0]   raw;
		logic [2:0]             take;
		logic [2:0][DATA_W-1:0] rem_nx;

		always_comb begin
			for (int j = 0; j < 3; j++) begin
				raw[j]    = {rem_dv_s[k][j], nb_dv_s[k][j]};
				take[j]   = (raw[j] >= {1'b0, len_dv_s[k]});
				rem_nx[j] = take[j] ? DATA_W'(raw[j] - {1'b0, len_dv_s[k]})
				                    : raw[j][DATA_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_dv_s[k+1] <= vld_dv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int j = 0; j < 3; j++) begin
					q_dv_s[k+1][j] <= {q_dv_s[k][j][Q_W-2:0], take[j]};
				end
				rem_dv_s[k+1] <= rem_nx;
				nb_dv_s[k+1]  <= '0;
				len_dv_s[k+1] <= len_dv_s[k];
				neg_dv_s[k+1] <= neg_dv_s[k];
				pay_dv_s[k+1] <= pay_dv_s[k];
			end
		end
	end

	logic [2:0][U_W-1:0] unit_nx;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (len_dv_s[DV_STEPS] == '0) begin
				unit_nx[j] = '0;
			end else if (neg_dv_s[DV_STEPS][j]) begin
				unit_nx[j] = U_W'(-{1'b0, q_dv_s[DV_STEPS][j]});
			end else begin
				unit_nx[j] = {1'b0, q_dv_s[DV_STEPS][j]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_dv_s[DV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			unit_out <= unit_nx;
			len_out  <= len_dv_s[DV_STEPS];
			pay_out  <= pay_dv_s[DV_STEPS];
		end
	end

endmodule
`default_nettype wire

@@ rtl/cosf_cross.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined fixed-point cross product
// Forms the six partial products of two unit vectors, then takes the exact
// differences and rounds them to the working fraction, ties away from zero.
// ----------------------------------------------------------------------------
module cosf_cross import cosf_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int PW        = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_valid,
	input  logic [2:0][FRAC_BITS+1:0] a_in,
	input  logic [2:0][FRAC_BITS+1:0] b_in,
	input  logic [PW-1:0]             pay_in,
	output logic                      out_valid,
	output logic [2:0][DATA_W-1:0]    c_out,
	output logic [PW-1:0]             pay_out
);

	localparam int U_W = FRAC_BITS + 2;
	localparam int P_W = 2 * U_W;
	localparam int D_W = P_W + 1;
	localparam int WIDE_W = 64;

	logic                  vld_s1;
	logic [5:0][P_W-1:0]   prod_s1;
	logic [PW-1:0]         pay_s1;
	logic [5:0][P_W-1:0]   prod_nx;

	always_comb begin
		logic signed [P_W-1:0] p;
		for (int j = 0; j < 6; j++) begin
			unique case (j)
				0: p = $signed(a_in[1]) * $signed(b_in[2]);
				1: p = $signed(a_in[2]) * $signed(b_in[1]);
				2: p = $signed(a_in[2]) * $signed(b_in[0]);
				3: p = $signed(a_in[0]) * $signed(b_in[2]);
				4: p = $signed(a_in[0]) * $signed(b_in[1]);
				default: p = $signed(a_in[1]) * $signed(b_in[0]);
			endcase
			prod_nx[j] = p;
		end
	end

	logic [2:0][DATA_W-1:0] c_nx;

	always_comb begin
		logic signed [D_W-1:0]    diff;
		logic [D_W-1:0]           m;
		logic [D_W-1:0]           r;
		logic signed [D_W-1:0]    sv;
		logic signed [WIDE_W-1:0] wide;
		for (int i = 0; i < 3; i++) begin
			diff = $signed(prod_s1[2*i]) - $signed(prod_s1[2*i+1]);
			m    = diff[D_W-1] ? D_W'(-diff) : diff;
			r    = (m >> FRAC_BITS) + D_W'(m[FRAC_BITS-1]);
			sv   = diff[D_W-1] ? D_W'(-r) : r;
			wide = sv;
			c_nx[i] = wide[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_valid;
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= prod_nx;
			pay_s1  <= pay_in;
			c_out   <= c_nx;
			pay_out <= pay_s1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/circular_orbit_steering_force.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Circular orbit steering force
// Adds a tangential push around a configured center and a radial correction
// outside the inner/outer ring to an agent's accumulated force, saturated; when disabled the force passes through.
// ----------------------------------------------------------------------------
//  Channel   Signals                           Handshake
//  config    psel penable pwrite paddr pwdata  APB write, pready tied high
//  request   pos_* vel_* force_in_*            in_valid / in_stall
//  result    force_out_*                       out_valid / out_stall
//
// One request enters per cycle while in_stall is low. The result path runs
// through two normalizers in series, each a 32-stage square root followed
// by a FRAC_BITS+1 stage divider. A two-entry result queue backs the
// pipeline; in_stall rises only when it holds two unread results.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module circular_orbit_steering_force import cosf_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] pos_x,
	input  logic signed [DATA_W-1:0] pos_y,
	input  logic signed [DATA_W-1:0] pos_z,
	input  logic signed [DATA_W-1:0] vel_x,
	input  logic signed [DATA_W-1:0] vel_y,
	input  logic signed [DATA_W-1:0] vel_z,
	input  logic signed [DATA_W-1:0] force_in_x,
	input  logic signed [DATA_W-1:0] force_in_y,
	input  logic signed [DATA_W-1:0] force_in_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] force_out_x,
	output logic signed [DATA_W-1:0] force_out_y,
	output logic signed [DATA_W-1:0] force_out_z
);

	localparam int U_W    = FRAC_BITS + 2;
	localparam int R_W    = DATA_W - 1;
	localparam int DF_W   = DATA_W + 2;
	localparam int PR_W   = 2 * DATA_W;
	localparam int SM_W   = PR_W - FRAC_BITS;
	localparam int TT_W   = DATA_W + 2;
	localparam int ACC_W  = 67 - FRAC_BITS;
	localparam int FV_W   = 3 * DATA_W;
	localparam int PW1    = 3 * U_W + DATA_W + FV_W + 1;
	localparam int FIFO_N = 2;

	localparam logic [R_W-1:0]    RIN_RST  = R_W'(2 << FRAC_BITS);
	localparam logic [R_W-1:0]    ROUT_RST = R_W'(3 << FRAC_BITS);
	localparam logic [DATA_W-1:0] TENTH    = DATA_W'(((1 << FRAC_BITS) + 5) / 10);

	// Configuration registers.
	logic              enable_q;
	logic [DATA_W-1:0] cx_q, cy_q, cz_q;
	logic [R_W-1:0]    rin_q, rout_q;
	logic [DATA_W-1:0] rg_q, tg_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			cx_q     <= '0;
			cy_q     <= '0;
			cz_q     <= '0;
			rin_q    <= RIN_RST;
			rout_q   <= ROUT_RST;
			rg_q     <= TENTH;
			tg_q     <= TENTH;
		end else if (psel && penable && pwrite && pready) begin
			unique case (cosf_reg_t'(paddr[ADDR_W-1:2]))
				REG_ENABLE:       enable_q <= pwdata[0];
				REG_CENTER_X:     cx_q     <= pwdata;
				REG_CENTER_Y:     cy_q     <= pwdata;
				REG_CENTER_Z:     cz_q     <= pwdata;
				REG_INNER_RADIUS: rin_q    <= pwdata[R_W-1:0];
				REG_OUTER_RADIUS: rout_q   <= pwdata[R_W-1:0];
				REG_RADIAL_GAIN:  rg_q     <= pwdata;
				REG_TANGENT_GAIN: tg_q     <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (cosf_reg_t'(paddr[ADDR_W-1:2]))
			REG_ENABLE:       prdata = {{(DATA_W-1){1'b0}}, enable_q};
			REG_CENTER_X:     prdata = cx_q;
			REG_CENTER_Y:     prdata = cy_q;
			REG_CENTER_Z:     prdata = cz_q;
			REG_INNER_RADIUS: prdata = {1'b0, rin_q};
			REG_OUTER_RADIUS: prdata = {1'b0, rout_q};
			REG_RADIAL_GAIN:  prdata = rg_q;
			REG_TANGENT_GAIN: prdata = tg_q;
		endcase
	end

	// Pipeline advance and result queue.
	logic [1:0]             cnt_q;
	logic                   wp_q, rp_q;
	logic [2:0][DATA_W-1:0] fifo_q [FIFO_N];
	logic                   adv, push, pop;
	logic                   vld_s6;
	logic [2:0][DATA_W-1:0] res_nx;

	assign adv       = (cnt_q != 2'(FIFO_N));
	assign in_stall  = !adv;
	assign out_valid = (cnt_q != 2'd0);
	assign push      = vld_s6 && adv;
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= res_nx;
		end
	end

	assign force_out_x = fifo_q[rp_q][0];
	assign force_out_y = fifo_q[rp_q][1];
	assign force_out_z = fifo_q[rp_q][2];

	// Stage 1: center offset, saturated.
	logic                   vld_s1, en_s1;
	logic [2:0][DATA_W-1:0] d_s1, v_s1, f_s1;
	logic [2:0][DATA_W-1:0] d_nx;

	always_comb begin
		logic signed [DATA_W:0] df;
		for (int i = 0; i < 3; i++) begin
			unique case (i)
				0: df = $signed(cx_q) - pos_x;
				1: df = $signed(cy_q) - pos_y;
				default: df = $signed(cz_q) - pos_z;
			endcase
			if (df[DATA_W] != df[DATA_W-1]) begin
				d_nx[i] = df[DATA_W] ? S32_MIN : S32_MAX;
			end else begin
				d_nx[i] = df[DATA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1  <= d_nx;
			v_s1  <= {vel_z, vel_y, vel_x};
			f_s1  <= {force_in_z, force_in_y, force_in_x};
			en_s1 <= enable_q;
		end
	end

	// Center direction and velocity direction.
	logic                   nd_vld, nv_vld;
	logic [2:0][U_W-1:0]    u_nd, u_nv;
	logic [DATA_W-1:0]      dist_nd, len_nv;
	logic [FV_W-1:0]        f_nd;
	logic                   en_nv;

	cosf_norm3 #(.FRAC_BITS(FRAC_BITS), .PW(FV_W)) u_norm_d (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (vld_s1),
		.vec_in   (d_s1),
		.pay_in   (f_s1),
		.out_valid(nd_vld),
		.unit_out (u_nd),
		.len_out  (dist_nd),
		.pay_out  (f_nd)
	);

	cosf_norm3 #(.FRAC_BITS(FRAC_BITS), .PW(1)) u_norm_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (vld_s1),
		.vec_in   (v_s1),
		.pay_in   (en_s1),
		.out_valid(nv_vld),
		.unit_out (u_nv),
		.len_out  (len_nv),
		.pay_out  (en_nv)
	);

	// First cross product, its normalization, and the second cross product.
	logic                   c1_vld, nc_vld, c2_vld;
	logic [2:0][DATA_W-1:0] c1_vec, t_vec;
	logic [PW1-1:0]         pay_c1, pay_nc, pay_c2;
	logic [2:0][U_W-1:0]    w_nc, u_nc;
	logic [DATA_W-1:0]      len_nc;

	cosf_cross #(.FRAC_BITS(FRAC_BITS), .PW(PW1)) u_cross_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (nd_vld),
		.a_in     (u_nd),
		.b_in     (u_nv),
		.pay_in   ({u_nd, dist_nd, f_nd, en_nv}),
		.out_valid(c1_vld),
		.c_out    (c1_vec),
		.pay_out  (pay_c1)
	);

	cosf_norm3 #(.FRAC_BITS(FRAC_BITS), .PW(PW1)) u_norm_c (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (c1_vld),
		.vec_in   (c1_vec),
		.pay_in   (pay_c1),
		.out_valid(nc_vld),
		.unit_out (w_nc),
		.len_out  (len_nc),
		.pay_out  (pay_nc)
	);

	assign u_nc = pay_nc[PW1-1 -: 3*U_W];

	cosf_cross #(.FRAC_BITS(FRAC_BITS), .PW(PW1)) u_cross_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (nc_vld),
		.a_in     (w_nc),
		.b_in     (u_nc),
		.pay_in   (pay_nc),
		.out_valid(c2_vld),
		.c_out    (t_vec),
		.pay_out  (pay_c2)
	);

	// Stage 2: ring test and distance error.
	logic                   vld_s2, en_s2;
	logic [2:0][DATA_W-1:0] t_s2, f_s2;
	logic [2:0][U_W-1:0]    u_s2;
	logic [DF_W-1:0]        diff_s2;
	logic [DATA_W-1:0]      dist_c2;
	logic [DF_W-1:0]        diff_nx;

	assign dist_c2 = pay_c2[FV_W+DATA_W:FV_W+1];

	always_comb begin
		logic [DF_W-1:0] de, ie, oe;
		de = {2'b00, dist_c2};
		ie = {3'b000, rin_q};
		oe = {3'b000, rout_q};
		priority if (de < ie) begin
			diff_nx = de - ie;
		end else if (de > oe) begin
			diff_nx = de - oe;
		end else begin
			diff_nx = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2    <= t_vec;
			u_s2    <= pay_c2[PW1-1 -: 3*U_W];
			f_s2    <= pay_c2[FV_W:1];
			en_s2   <= pay_c2[0];
			diff_s2 <= diff_nx;
		end
	end

	// Stage 3: gain products.
	logic                   vld_s3, en_s3, dneg_s3;
	logic [PR_W-1:0]        dp_s3;
	logic [2:0][PR_W-1:0]   tp_s3;
	logic [2:0]             tneg_s3;
	logic [2:0][U_W-1:0]    u_s3;
	logic [2:0][DATA_W-1:0] f_s3;
	logic [DATA_W:0]        dmag;

	assign dmag = diff_s2[DF_W-1] ? (DATA_W+1)'(-diff_s2)
	                              : diff_s2[DATA_W:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			dp_s3   <= PR_W'(dmag * mag_of(rg_q));
			dneg_s3 <= diff_s2[DF_W-1] ^ rg_q[DATA_W-1];
			for (int i = 0; i < 3; i++) begin
				tp_s3[i]   <= PR_W'(mag_of(t_s2[i]) * mag_of(tg_q));
				tneg_s3[i] <= t_s2[i][DATA_W-1] ^ tg_q[DATA_W-1];
			end
			u_s3  <= u_s2;
			f_s3  <= f_s2;
			en_s3 <= en_s2;
		end
	end

	// Stage 4: rounding of the radial scale and the tangential terms.
	logic                   vld_s4, en_s4, sneg_s4;
	logic [SM_W-1:0]        smag_s4;
	logic [2:0][TT_W-1:0]   tt_s4;
	logic [2:0][U_W-1:0]    u_s4;
	logic [2:0][DATA_W-1:0] f_s4;
	logic [SM_W-1:0]        smag_nx;
	logic [2:0][TT_W-1:0]   tt_nx;

	always_comb begin
		logic [PR_W-1:0] r;
		smag_nx = SM_W'((dp_s3 >> FRAC_BITS) + PR_W'(dp_s3[FRAC_BITS-1]));
		for (int i = 0; i < 3; i++) begin
			r = (tp_s3[i] >> FRAC_BITS) + PR_W'(tp_s3[i][FRAC_BITS-1]);
			tt_nx[i] = tneg_s3[i] ? TT_W'(-r) : TT_W'(r);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			smag_s4 <= smag_nx;
			sneg_s4 <= dneg_s3;
			tt_s4   <= tt_nx;
			u_s4    <= u_s3;
			f_s4    <= f_s3;
			en_s4   <= en_s3;
		end
	end

	// Stage 5: radial products along the center direction.
	logic                   vld_s5, en_s5;
	logic [2:0][PR_W-1:0]   up_s5;
	logic [2:0]             uneg_s5;
	logic [2:0][TT_W-1:0]   tt_s5;
	logic [2:0][DATA_W-1:0] f_s5;
	logic [2:0][U_W-1:0]    umag;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			umag[i] = u_s4[i][U_W-1] ? U_W'(-u_s4[i]) : u_s4[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				up_s5[i]   <= PR_W'(umag[i] * smag_s4);
				uneg_s5[i] <= u_s4[i][U_W-1] ^ sneg_s4;
			end
			tt_s5 <= tt_s4;
			f_s5  <= f_s4;
			en_s5 <= en_s4;
		end
	end

	// Stage 6: sum with the incoming force.
	logic                   en_s6;
	logic [2:0][ACC_W-1:0]  acc_s6;
	logic [2:0][DATA_W-1:0] f_s6;
	logic [2:0][ACC_W-1:0]  acc_nx;

	always_comb begin
		logic [PR_W-1:0]         r;
		logic signed [ACC_W-1:0] a_f, a_t, a_u;
		for (int i = 0; i < 3; i++) begin
			r   = (up_s5[i] >> FRAC_BITS) + PR_W'(up_s5[i][FRAC_BITS-1]);
			a_f = $signed(f_s5[i]);
			a_t = $signed(tt_s5[i]);
			a_u = uneg_s5[i] ? ACC_W'(-r) : ACC_W'(r);
			acc_nx[i] = a_f + a_t + a_u;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s6 <= acc_nx;
			f_s6   <= f_s5;
			en_s6  <= en_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= c2_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Final saturation, or pass-through when disabled.
	always_comb begin
		logic [ACC_W-DATA_W:0] hi;
		for (int i = 0; i < 3; i++) begin
			hi = acc_s6[i][ACC_W-1:DATA_W-1];
			if (!en_s6) begin
				res_nx[i] = f_s6[i];
			end else if (hi == '0 || hi == '1) begin
				res_nx[i] = acc_s6[i][DATA_W-1:0];
			end else begin
				res_nx[i] = acc_s6[i][ACC_W-1] ? S32_MIN : S32_MAX;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_norm_align: assert property (@(posedge clk) disable iff (!arst_n)
		nd_vld == nv_vld)
		else $error("normalizer lanes out of step");

	a_cross_len: assert property (@(posedge clk) disable iff (!arst_n)
		nc_vld |-> (len_nc < (DATA_W'(1) << (FRAC_BITS + 2))))
		else $error("cross product length exceeds unit bound");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && cnt_q == 2'(FIFO_N)))
		else $error("request stalled without a full result queue");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("waiting result dropped");

	a_len_v: assert property (@(posedge clk) disable iff (!arst_n)
		(nv_vld && len_nv == '0) |-> (u_nv == '0))
		else $error("zero velocity gave a nonzero direction");

endmodule
`default_nettype wire

@@ tb/circular_orbit_steering_force_test.sv @@
// ----------------------------------------------------------------------------
// Circular orbit steering force testbench
// Drives position, velocity and force requests through the valid/stall
// channel, programs the registers over the APB port between phases, and
// compares each result against a fixed-point predictor of the steering force.
// ----------------------------------------------------------------------------
module circular_orbit_steering_force_test;
	import cosf_pkg::*;

	localparam int FB = 16;
	localparam int LATENCY = 2*FB + 85;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic signed [31:0] vel_x = 0, vel_y = 0, vel_z = 0;
	logic signed [31:0] force_in_x = 0, force_in_y = 0, force_in_z = 0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] force_out_x, force_out_y, force_out_z;

	typedef struct {
		logic signed [31:0] fx, fy, fz;
	} force_t;

	force_t expected_forces[$];
	int errors = 0;
	int idle_cycles = 0;
	bit stall_quiet = 0;

	logic        steer_enable;
	longint      ctr[3];
	longint      r_inner, r_outer, g_radial, g_tangent;

	circular_orbit_steering_force DUT (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint round_fix(longint x);
		longint m;
		m = abs64(x);
		m = (m >>> FB) + ((m >>> (FB-1)) & 1);
		return x < 0 ? -m : m;
	endfunction

	function automatic longint mul_fix(longint a, longint b);
		logic [63:0] p;
		longint r;
		p = 64'(abs64(a)) * 64'(abs64(b));
		r = longint'((p >> FB) + ((p >> (FB-1)) & 1));
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic longint sqrt_floor(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	function automatic longint unit_vector(input longint v[3], output longint u[3]);
		logic [63:0] sum;
		longint len;
		sum = 0;
		for (int i = 0; i < 3; i++) sum += 64'(abs64(v[i])) * 64'(abs64(v[i]));
		len = sqrt_floor(sum);
		for (int i = 0; i < 3; i++) begin
			if (len == 0) u[i] = 0;
			else begin
				u[i] = longint'((64'(abs64(v[i])) << FB) / 64'(len));
				if (v[i] < 0) u[i] = -u[i];
			end
		end
		return len;
	endfunction

	function automatic void cross_fix(input longint a[3], input longint b[3],
			output longint c[3]);
		c[0] = round_fix(a[1]*b[2] - a[2]*b[1]);
		c[1] = round_fix(a[2]*b[0] - a[0]*b[2]);
		c[2] = round_fix(a[0]*b[1] - a[1]*b[0]);
	endfunction

	function automatic force_t steering_force(logic signed [31:0] p[3],
			logic signed [31:0] v[3], logic signed [31:0] f[3]);
		longint d[3], u[3], vv[3], nv[3], c[3], w[3], t[3], o[3];
		longint dist_len, scale, acc;
		bit radial;
		force_t res;
		scale = 0;
		radial = 0;
		if (!steer_enable) begin
			res.fx = f[0];
			res.fy = f[1];
			res.fz = f[2];
			return res;
		end
		for (int i = 0; i < 3; i++) begin
			d[i] = sat32(ctr[i] - longint'(p[i]));
			vv[i] = longint'(v[i]);
		end
		dist_len = unit_vector(d, u);
		void'(unit_vector(vv, nv));
		cross_fix(u, nv, c);
		void'(unit_vector(c, w));
		cross_fix(w, u, t);
		if (dist_len < r_inner) begin
			scale = mul_fix(dist_len - r_inner, g_radial);
			radial = 1;
		end else if (dist_len > r_outer) begin
			scale = mul_fix(dist_len - r_outer, g_radial);
			radial = 1;
		end
		for (int i = 0; i < 3; i++) begin
			acc = longint'(f[i]) + mul_fix(t[i], g_tangent);
			if (radial) acc += mul_fix(u[i], scale);
			o[i] = sat32(acc);
		end
		res.fx = o[0][31:0];
		res.fy = o[1][31:0];
		res.fz = o[2][31:0];
		return res;
	endfunction

	task automatic write_reg(cosf_reg_t r, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(r));
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_ENABLE:       steer_enable = value[0];
			REG_CENTER_X:     ctr[0] = longint'(signed'(value));
			REG_CENTER_Y:     ctr[1] = longint'(signed'(value));
			REG_CENTER_Z:     ctr[2] = longint'(signed'(value));
			REG_INNER_RADIUS: r_inner = longint'(value[30:0]);
			REG_OUTER_RADIUS: r_outer = longint'(value[30:0]);
			REG_RADIAL_GAIN:  g_radial = longint'(signed'(value));
			REG_TANGENT_GAIN: g_tangent = longint'(signed'(value));
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (expected_forces.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_request(logic signed [31:0] p[3], logic signed [31:0] v[3],
			logic signed [31:0] f[3], bit gaps);
		int g;
		g = gaps ? gap_length() : 0;
		repeat (g) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		expected_forces.push_back(steering_force(p, v, f));
		in_valid <= 1'b1;
		{pos_x, pos_y, pos_z} = {p[0], p[1], p[2]};
		{vel_x, vel_y, vel_z} = {v[0], v[1], v[2]};
		{force_in_x, force_in_y, force_in_z} = {f[0], f[1], f[2]};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic finish_requests();
		in_valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] any_word();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 0;
			3: return $urandom;
			default: return signed'(32'($urandom_range(0, 32'h000F_FFFF))) -
				32'sh0008_0000;
		endcase
	endfunction

	function automatic logic signed [31:0] near_word(logic signed [31:0] c);
		return c + signed'(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
	endfunction

	task automatic random_requests(int n, bit wild);
		logic signed [31:0] p[3], v[3], f[3];
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < 3; i++) begin
				p[i] = wild ? any_word() : near_word(32'(ctr[i]));
				v[i] = ($urandom_range(0, 3) == 0) ? any_word() : near_word(0);
				f[i] = ($urandom_range(0, 4) == 0) ? any_word() : near_word(0);
			end
			if ($urandom_range(0, 30) == 0) v = '{0, 0, 0};
			if ($urandom_range(0, 30) == 0)
				for (int i = 0; i < 3; i++) v[i] = 32'(ctr[i]) - p[i];
			send_request(p, v, f, 1);
		end
		finish_requests();
	endtask

	task automatic test_directed();
		logic signed [31:0] z[3], mx[3], mn[3];
		z = '{0, 0, 0};
		mx = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
		mn = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
		send_request(z, z, z, 0);
		send_request(z, '{32'sh10000, 0, 0}, mx, 0);
		send_request('{32'sh10000, 0, 0}, '{0, 32'sh10000, 0}, z, 0);
		send_request('{32'sh28000, 0, 0}, '{0, 0, 32'sh10000}, z, 0);
		send_request('{32'sh50000, 0, 0}, '{0, 32'sh10000, 0}, mn, 0);
		send_request('{32'sh30000, 0, 0}, '{32'sh10000, 0, 0}, z, 0);
		send_request(mx, mn, mx, 0);
		send_request(mn, mx, mn, 0);
		send_request(mx, mx, z, 0);
		send_request(mn, mn, z, 0);
		send_request('{32'sh20000, 0, 0}, '{0, -32'sh10000, 0}, mx, 0);
		send_request('{32'sh0, 32'sh30000, 0}, '{0, 0, -32'sh7000}, z, 0);
		send_request(z, mx, mn, 0);
		finish_requests();
		wait_drained();
	endtask

	task automatic test_disabled();
		write_reg(REG_ENABLE, 32'h0);
		random_requests(60, 1);
		wait_drained();
		write_reg(REG_ENABLE, 32'h1);
	endtask

	task automatic test_default_ring();
		random_requests(300, 0);
		wait_drained();
	endtask

	task automatic test_shifted_center();
		write_reg(REG_CENTER_X, 32'h0012_8000);
		write_reg(REG_CENTER_Y, 32'hFFF0_4000);
		write_reg(REG_CENTER_Z, 32'h0003_0000);
		write_reg(REG_INNER_RADIUS, 32'h0001_0000);
		write_reg(REG_OUTER_RADIUS, 32'h0004_0000);
		write_reg(REG_RADIAL_GAIN, 32'hFFFE_0000);
		write_reg(REG_TANGENT_GAIN, 32'h0003_8000);
		random_requests(250, 0);
		wait_drained();
	endtask

	task automatic test_extreme_settings();
		write_reg(REG_CENTER_X, 32'h7FFF_FFFF);
		write_reg(REG_CENTER_Y, 32'h8000_0000);
		write_reg(REG_CENTER_Z, 32'h0);
		write_reg(REG_INNER_RADIUS, 32'h7FFF_FFFF);
		write_reg(REG_OUTER_RADIUS, 32'h0);
		write_reg(REG_RADIAL_GAIN, 32'h7FFF_FFFF);
		write_reg(REG_TANGENT_GAIN, 32'h8000_0000);
		random_requests(200, 1);
		wait_drained();
		write_reg(REG_INNER_RADIUS, 32'h0);
		write_reg(REG_OUTER_RADIUS, 32'h7FFF_FFFF);
		write_reg(REG_RADIAL_GAIN, 32'h8000_0000);
		write_reg(REG_TANGENT_GAIN, 32'h7FFF_FFFF);
		random_requests(150, 1);
		wait_drained();
	endtask

	task automatic test_wide_random();
		write_reg(REG_CENTER_X, $urandom);
		write_reg(REG_CENTER_Y, $urandom);
		write_reg(REG_CENTER_Z, $urandom);
		write_reg(REG_INNER_RADIUS, $urandom_range(0, 32'h0010_0000));
		write_reg(REG_OUTER_RADIUS, $urandom_range(0, 32'h0040_0000));
		write_reg(REG_RADIAL_GAIN, $urandom);
		write_reg(REG_TANGENT_GAIN, $urandom);
		random_requests(100, 1);
		random_requests(80, 0);
		wait_drained();
	endtask

	initial begin
		steer_enable = 1'b1;
		ctr = '{0, 0, 0};
		r_inner = 2 << FB;
		r_outer = 3 << FB;
		g_radial = ((64'sd1 << FB) + 5) / 10;
		g_tangent = g_radial;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_disabled();
		test_default_ring();
		stall_quiet = 1;
		test_shifted_center();
		stall_quiet = 0;
		test_extreme_settings();
		test_wide_random();
		if (errors == 0) $display("circular_orbit_steering_force_test passed");
		else $display("circular_orbit_steering_force_test failed");
		$finish;
	end

	always @(negedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (stall_quiet) out_stall <= 1'b0;
		else if (out_stall) out_stall <= (r < 70);
		else out_stall <= (r < 20);
	end

	always @(posedge clk) begin
		force_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_forces.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				e = expected_forces.pop_front();
				if (force_out_x !== e.fx) begin
					$error("force_out_x expected %0d actual %0d", e.fx, force_out_x);
					errors++;
				end
				if (force_out_y !== e.fy) begin
					$error("force_out_y expected %0d actual %0d", e.fy, force_out_y);
					errors++;
				end
				if (force_out_z !== e.fz) begin
					$error("force_out_z expected %0d actual %0d", e.fz, force_out_z);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel ||
				expected_forces.size() == 0)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("circular_orbit_steering_force_test failed");
			$finish;
		end
	end

endmodule
